/* rtl/tfb_pkg.sv */
// tfb_pkg: shared types, constants and the CRC byte step for the telemetry frame builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tfb_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int WORD_W  = 16;
	localparam int NUM_SENS = 5;
	localparam int IN_W    = WORD_W * NUM_SENS;

	localparam logic [15:0] CRC_TOP = 16'h8000;
	localparam logic [15:0] WORD_LO = 16'h00FF;

	typedef enum logic [2:0] {
		REG_SRC, REG_DST, REG_BIG, REG_TYPE, REG_POLY, REG_FLAG, REG_ESC, REG_XOR
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  src_addr;
		logic [7:0]  dst_addr;
		logic        big_endian;
		logic [7:0]  type_code;
		logic [15:0] crc_poly;
		logic [7:0]  flag_byte;
		logic [7:0]  escape_byte;
		logic [7:0]  escape_xor;
	} cfg_t;

	// queue word: byte, stuffing allowed, closing flag
	typedef struct packed {
		logic [7:0] data;
		logic       stuff;
		logic       last;
	} qent_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] acc;
		logic        top;
		acc = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			top = (acc & CRC_TOP) != 16'h0000;
			acc = {acc[14:0], 1'b0};
			if (top) begin
				acc = acc ^ poly;
			end
		end
		return acc;
	endfunction

	function automatic logic [7:0] word_byte(input logic [15:0] w, input logic big,
			input logic second);
		logic [15:0] lo;
		lo = w & WORD_LO;
		return (big == second) ? lo[7:0] : w[15:8];
	endfunction

endpackage

/* rtl/telemetry_frame_builder_crc_stuffing_core.sv */
// telemetry_frame_builder_crc_stuffing_core: top level with configuration registers.
// Depends on tfb_pkg, tfb_front, tfb_queue and tfb_back.
//
// Usage:
//   s_axis: one word per frame; tdata holds tick_count, depth, therm_temp, humidity,
//   hum_temp (16 bits each, tick_count lowest). m_axis: one frame byte per word,
//   tlast on the closing flag. cfg_we/cfg_index/cfg_data write a register; write only
//   while no frame is in flight. Each input word yields one frame of 19 to 36 bytes:
//   flag, stuffed body and CRC, flag. The first byte passes the serializer state,
//   the queue and the output register before it is valid. The serializer produces one
//   unstuffed byte a cycle while the queue is not full; the output register sends
//   one byte a cycle while the receiver is ready. s_axis_tready returns the cycle
//   after the closing flag is queued, so no new input word is taken until the whole
//   frame is queued; longer stuffed frames are paced by the output.
//   A stalled receiver backs the four-word queue up to the serializer, which waits;
//   no byte is lost. Reset clears the packet counter, empties the queue, drops
//   the output word and loads the register defaults (flag 0x7E, escape 0x7D,
//   xor 0x20, polynomial 0x1021).
`timescale 1ns / 1ps

module telemetry_frame_builder_crc_stuffing_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [15:0]              cfg_data,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// tick_count, depth, therm_temp, humidity, hum_temp
	input  logic [tfb_pkg::IN_W-1:0] s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// out_byte
	output logic [7:0]               m_axis_tdata,
	output logic                     m_axis_tlast
);
	import tfb_pkg::*;

	cfg_t  cfg_q;
	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;
	qent_t q_wdata;
	qent_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_addr    <= 8'h00;
			cfg_q.dst_addr    <= 8'h00;
			cfg_q.big_endian  <= 1'b0;
			cfg_q.type_code   <= 8'h00;
			cfg_q.crc_poly    <= 16'h1021;
			cfg_q.flag_byte   <= 8'h7E;
			cfg_q.escape_byte <= 8'h7D;
			cfg_q.escape_xor  <= 8'h20;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SRC:  cfg_q.src_addr    <= cfg_data[7:0];
				REG_DST:  cfg_q.dst_addr    <= cfg_data[7:0];
				REG_BIG:  cfg_q.big_endian  <= cfg_data[0];
				REG_TYPE: cfg_q.type_code   <= cfg_data[7:0];
				REG_POLY: cfg_q.crc_poly    <= cfg_data;
				REG_FLAG: cfg_q.flag_byte   <= cfg_data[7:0];
				REG_ESC:  cfg_q.escape_byte <= cfg_data[7:0];
				REG_XOR:  cfg_q.escape_xor  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	tfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	tfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

/* rtl/tfb_front.sv */
// tfb_front: accepts a sample word, bumps the packet counter, and serializes the unstuffed
// frame (flags, body, CRC) into the queue one byte a cycle while it is not full. Uses tfb_pkg.
`timescale 1ns / 1ps

module tfb_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tfb_pkg::cfg_t           cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [tfb_pkg::IN_W-1:0] in_data,
	input  logic                    q_full,
	output logic                    q_push,
	output tfb_pkg::qent_t          q_data
);
	import tfb_pkg::*;

	typedef enum logic {F_IDLE, F_SEND} fstate_t;

	localparam logic [4:0] IDX_OPEN  = 5'd0;
	localparam logic [4:0] IDX_SRC   = 5'd1;
	localparam logic [4:0] IDX_DST   = 5'd2;
	localparam logic [4:0] IDX_CNT   = 5'd3;
	localparam logic [4:0] IDX_TYPE  = 5'd5;
	localparam logic [4:0] IDX_TICK  = 5'd6;
	localparam logic [4:0] IDX_CRC   = 5'd16;
	localparam logic [4:0] IDX_CLOSE = 5'd18;

	fstate_t     state_q;
	logic [4:0]  idx_q;
	logic [15:0] cnt_q;
	logic [15:0] crc_q;
	logic [15:0] sens_q [NUM_SENS];

	logic [4:0]  rel;
	logic [2:0]  wsel;
	logic        body;

	assign in_ready = (state_q == F_IDLE);
	assign q_push   = (state_q == F_SEND) && !q_full;
	assign rel      = idx_q - IDX_TICK;
	assign wsel     = rel[3:1];
	assign body     = (idx_q >= IDX_SRC) && (idx_q < IDX_CRC);

	always_comb begin
		q_data = '{data: 8'h00, stuff: 1'b1, last: 1'b0};
		unique case (idx_q) inside
			IDX_OPEN: q_data = '{data: cfg.flag_byte, stuff: 1'b0, last: 1'b0};
			IDX_SRC:  q_data.data = cfg.src_addr;
			IDX_DST:  q_data.data = cfg.dst_addr;
			IDX_CNT, IDX_CNT + 5'd1:
				q_data.data = word_byte(cnt_q, cfg.big_endian, idx_q != IDX_CNT);
			IDX_TYPE: q_data.data = cfg.type_code;
			[IDX_TICK:IDX_CRC - 5'd1]:
				q_data.data = word_byte(sens_q[wsel], cfg.big_endian, rel[0]);
			IDX_CRC, IDX_CRC + 5'd1:
				q_data.data = word_byte(crc_q, cfg.big_endian, idx_q != IDX_CRC);
			default:  q_data = '{data: cfg.flag_byte, stuff: 1'b0, last: 1'b1};
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int i = 0; i < NUM_SENS; i++) begin
				sens_q[i] <= in_data[i*WORD_W +: WORD_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			idx_q   <= IDX_OPEN;
			cnt_q   <= '0;
			crc_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_SEND;
						idx_q   <= IDX_OPEN;
						crc_q   <= '0;
						cnt_q   <= cnt_q + 16'd1;
					end
				end
				F_SEND: begin
					if (q_push) begin
						if (body) begin
							crc_q <= crc_byte(crc_q, q_data.data, cfg.crc_poly);
						end
						if (idx_q == IDX_CLOSE) begin
							state_q <= F_IDLE;
						end else begin
							idx_q <= idx_q + 5'd1;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

/* rtl/tfb_queue.sv */
// tfb_queue: short word queue between the frame serializer and the stuffing stage.
// Uses tfb_pkg for the entry type and depth.
`timescale 1ns / 1ps

module tfb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tfb_pkg::qent_t wdata,
	output logic           full,
	input  logic           pop,
	output tfb_pkg::qent_t rdata,
	output logic           empty
);
	import tfb_pkg::*;

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue pop while empty");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule

/* rtl/tfb_back.sv */
// tfb_back: drains the queue, inserts escape sequences and holds the output register.
// Uses tfb_pkg for the config and entry types.
`timescale 1ns / 1ps

module tfb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tfb_pkg::cfg_t  cfg,
	input  logic           q_empty,
	input  tfb_pkg::qent_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           out_last
);
	import tfb_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       esc_q;
	logic [7:0] esc_data_q;
	logic       free;
	logic       hit;

	assign free      = !valid_q || out_ready;
	assign q_pop     = free && !esc_q && !q_empty;
	assign hit       = q_head.stuff &&
		((q_head.data == cfg.flag_byte) || (q_head.data == cfg.escape_byte));
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (free) begin
			if (esc_q) begin
				byte_q <= esc_data_q;
				last_q <= 1'b0;
			end else if (!q_empty) begin
				byte_q <= hit ? cfg.escape_byte : q_head.data;
				last_q <= q_head.last;
				if (hit) begin
					esc_data_q <= q_head.data ^ cfg.escape_xor;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			esc_q   <= 1'b0;
		end else if (free) begin
			if (esc_q) begin
				valid_q <= 1'b1;
				esc_q   <= 1'b0;
			end else begin
				valid_q <= !q_empty;
				esc_q   <= !q_empty && hit;
			end
		end
	end

	a_esc_follows: assert property (@(posedge clk) disable iff (!arst_n) esc_q |-> valid_q)
		else $error("pending escape without a word in the output register");
	a_no_pop_on_esc: assert property (@(posedge clk) disable iff (!arst_n) esc_q |-> !q_pop)
		else $error("queue popped while an escaped byte is pending");

endmodule
